FILE: rtl/tesq_pkg.sv
// Package for the timed event sorted queue: payload structs, opcodes, FSM states
// and the controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tesq_pkg;

    localparam logic [1:0] OP_AT     = 2'd0;
    localparam logic [1:0] OP_DELAY  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         event_id;
        logic [31:0]        due_tick;
        logic signed [31:0] delay;
        logic [31:0]        now_tick;
    } t_in_item;

    typedef struct packed {
        logic        head_valid;
        logic [3:0]  head_id;
        logic [31:0] head_due;
        logic        was_queued;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic remove;
        logic insert;
        logic result;
    } t_cmd;

    typedef struct packed {
        logic do_remove;
        logic do_insert;
    } t_status;

endpackage
`default_nettype wire

FILE: rtl/tesq_datapath.sv
// Datapath of the sorted queue: a chain of slot registers that shifts to remove
// or insert one event per cycle, plus queued flags. Depends on tesq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tesq_datapath #(
    parameter int MAX_EVENTS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tesq_pkg::t_cmd      i_cmd,
    input  tesq_pkg::t_in_item  i_item,
    output tesq_pkg::t_status   o_status,
    output tesq_pkg::t_out_item o_result
);
    localparam int CW = $clog2(MAX_EVENTS + 1);

    logic [3:0]            r_id [MAX_EVENTS];
    logic [31:0]           r_tick [MAX_EVENTS];
    logic [15:0]           r_flag;
    logic [CW-1:0]         r_occ;
    tesq_pkg::t_in_item    r_item;
    logic                  r_was;
    logic                  r_known;
    tesq_pkg::t_out_item   r_result;

    logic [31:0]           w_new_tick;
    logic                  w_room;
    logic [MAX_EVENTS-1:0] w_match;
    logic [MAX_EVENTS-1:0] w_after;
    logic [MAX_EVENTS-1:0] w_used;
    logic [MAX_EVENTS-1:0] w_hit;
    logic [MAX_EVENTS-1:0] w_ins;
    logic [MAX_EVENTS-1:0] w_ge;
    logic [MAX_EVENTS-1:0] w_first;

    assign w_new_tick = (r_item.opcode == tesq_pkg::OP_AT) ? r_item.due_tick :
                        r_item.now_tick + r_item.delay;
    assign w_room = (r_occ < CW'(MAX_EVENTS));

    // Per-cell compares: the one holding the id, and those later than the new tick.
    always_comb begin
        for (int k = 0; k < MAX_EVENTS; k++) begin
            w_used[k]  = (CW'(k) < r_occ);
            w_match[k] = w_used[k] && (r_id[k] == r_item.event_id);
            w_after[k] = w_used[k] && (w_new_tick - r_tick[k] >= 32'h8000_0000);
        end
        // Wrap-aware order is not transitive, so the insert point is the first
        // later cell; w_ins covers that cell and every used cell after it.
        w_hit[0] = w_match[0];
        w_ins[0] = w_after[0];
        for (int k = 1; k < MAX_EVENTS; k++) begin
            w_hit[k] = w_match[k] || w_hit[k-1];
            w_ins[k] = w_used[k] && (w_after[k] || w_ins[k-1]);
        end
        for (int k = 0; k < MAX_EVENTS; k++) begin
            w_ge[k] = w_ins[k] || !w_used[k];
        end
        w_first[0] = w_ge[0];
        for (int k = 1; k < MAX_EVENTS; k++) begin
            w_first[k] = w_ge[k] && !w_ge[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.remove) begin
            for (int k = 1; k < MAX_EVENTS; k++) begin
                if (w_hit[k-1]) begin
                    r_id[k-1]   <= r_id[k];
                    r_tick[k-1] <= r_tick[k];
                end
            end
        end else if (i_cmd.insert && w_room) begin
            if (w_first[0]) begin
                r_id[0]   <= r_item.event_id;
                r_tick[0] <= w_new_tick;
            end
            for (int k = 1; k < MAX_EVENTS; k++) begin
                if (w_first[k]) begin
                    r_id[k]   <= r_item.event_id;
                    r_tick[k] <= w_new_tick;
                end else if (w_ge[k-1]) begin
                    r_id[k]   <= r_id[k-1];
                    r_tick[k] <= r_tick[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
            r_occ  <= '0;
        end else begin
            if (i_cmd.remove) begin
                r_occ <= r_occ - 1'b1;
            end
            if (i_cmd.insert && w_room) begin
                r_occ <= r_occ + 1'b1;
            end
            if (i_cmd.result && r_known) begin
                if (r_item.opcode == tesq_pkg::OP_AT || r_item.opcode == tesq_pkg::OP_DELAY) begin
                    r_flag[r_item.event_id] <= 1'b1;
                end else if (r_item.opcode == tesq_pkg::OP_REMOVE) begin
                    r_flag[r_item.event_id] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_known <= (32'(i_item.event_id) < 32'(MAX_EVENTS));
            r_was   <= (32'(i_item.event_id) < 32'(MAX_EVENTS)) &&
                       r_flag[i_item.event_id];
        end
        if (i_cmd.result) begin
            r_result.head_valid <= (r_occ != '0);
            r_result.head_id    <= (r_occ != '0) ? r_id[0] : 4'd0;
            r_result.head_due   <= (r_occ != '0) ? r_tick[0] : 32'd0;
            r_result.was_queued <= r_was;
        end
    end

    assign o_status.do_remove = r_known && r_was &&
        (r_item.opcode == tesq_pkg::OP_AT || r_item.opcode == tesq_pkg::OP_DELAY ||
         r_item.opcode == tesq_pkg::OP_REMOVE);
    assign o_status.do_insert = r_known &&
        (r_item.opcode == tesq_pkg::OP_AT || r_item.opcode == tesq_pkg::OP_DELAY);
    assign o_result = r_result;
endmodule
`default_nettype wire

FILE: rtl/tesq_ctrl.sv
// Controller of the sorted queue: sequences load, remove, insert and result
// steps and runs the output register handshake. Depends on tesq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tesq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  wire               i_ready,
    input  tesq_pkg::t_status i_status,
    output tesq_pkg::t_cmd    o_cmd
);
    tesq_pkg::t_state r_state, n_state;
    logic r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tesq_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_ready  = 1'b0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            tesq_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tesq_pkg::ST_REMOVE;
                end
            end
            tesq_pkg::ST_REMOVE: begin
                o_cmd.remove = i_status.do_remove;
                n_state      = tesq_pkg::ST_INSERT;
            end
            tesq_pkg::ST_INSERT: begin
                o_cmd.insert = i_status.do_insert;
                n_state      = tesq_pkg::ST_OUT;
            end
            tesq_pkg::ST_OUT: begin
                // The result register is free only once the previous transfer is done.
                if (!r_ovalid || i_ready) begin
                    o_cmd.result = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = tesq_pkg::ST_IDLE;
                end
            end
            default: n_state = tesq_pkg::ST_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;
endmodule
`default_nettype wire

FILE: rtl/timed_event_sorted_queue_unit.sv
// Top level of the timed event sorted queue. Depends on tesq_pkg, tesq_ctrl
// and tesq_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Keeps up to MAX_EVENTS event identifiers sorted by wrap-aware due tick, ties
// first in first out. Each item queues, requeues or removes one event and
// returns the head and whether that event was queued before. An item passes
// through these steps: the accepting edge captures it, the slot chain shifts
// out an old entry, then shifts in the new one, and then the result is
// registered. The slot chain moves one position per cycle, in its shift steps
// only, in every cell from the affected entry on at once. The next item is
// accepted while the previous result still waits, but its last step stalls
// until that result has been transferred.
module timed_event_sorted_queue_unit #(
    parameter int MAX_EVENTS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  tesq_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output tesq_pkg::t_out_item o_item
);
    tesq_pkg::t_cmd    w_cmd;
    tesq_pkg::t_status w_status;

    tesq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_status(w_status), .o_cmd(w_cmd)
    );

    tesq_datapath #(.MAX_EVENTS(MAX_EVENTS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_item,
        .o_status(w_status), .o_result(o_item)
    );
endmodule
`default_nettype wire
